/* sv/csl_pkg.sv */
// ============================================================================
// csl_pkg
// Shared widths, codes and controller/datapath interface types for the
// code symbol lookup block.
// ============================================================================
package csl_pkg;

    // Table geometry and the boot-ROM address window.
    localparam int unsigned BOOT_DEPTH = 256;
    localparam int unsigned CART_DEPTH = 4096;
    localparam logic [32:0] BOOT_LIMIT = 33'h0_0000_4000;

    localparam int unsigned BOOT_AW   = (BOOT_DEPTH > 1) ? $clog2(BOOT_DEPTH) : 1;
    localparam int unsigned CART_AW   = (CART_DEPTH > 1) ? $clog2(CART_DEPTH) : 1;
    localparam int unsigned MAX_DEPTH = (BOOT_DEPTH > CART_DEPTH) ? BOOT_DEPTH : CART_DEPTH;
    // Search bounds run from 0 up to the table depth itself.
    localparam int unsigned PTR_W     = $clog2(MAX_DEPTH + 1);

    // Field widths.
    localparam int unsigned OP_W       = 2;
    localparam int unsigned INDEX_W    = 12;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned NAME_W     = 16;
    localparam int unsigned BOOT_CNT_W = 9;
    localparam int unsigned CART_CNT_W = 13;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned ENTRY_W    = ADDR_W + NAME_W;

    // Stream packing.
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned S_TUSER_W = OP_W;
    localparam int unsigned M_TDATA_W = NAME_W + ADDR_W;
    localparam int unsigned M_TUSER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WR_BOOT = 2'd0,
        OP_WR_CART = 2'd1,
        OP_LOOKUP  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOOT_COUNT = 1'b0,
        CFG_CART_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_BOOT_INIT,
        S_CART_INIT,
        S_ISSUE,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;    // register the incoming beat
        logic wr_boot;    // write the held entry into the boot-ROM table
        logic wr_cart;    // write the held entry into the cartridge table
        logic init;       // open a new search range
        logic init_boot;  // the new range covers the boot-ROM table
        logic issue;      // read the midpoint entry
        logic check;      // compare the returned entry and narrow the range
        logic publish;    // load the output register
    } t_ctrl_cmd;

    typedef struct packed {
        t_op  op;
        logic below_limit;
        logic range_empty;
        logic hit;
        logic table_boot;
        logic out_free;
    } t_dp_status;

endpackage

/* sv/code_symbol_lookup_unit.sv */
// ============================================================================
// code_symbol_lookup_unit
// Resolves a program counter to the code symbol that contains it, using a
// boot-ROM symbol table and a cartridge symbol table held in on-chip RAM.
// ============================================================================
// Sequence: a load beat is accepted, then written to its table. A lookup
//   is accepted and decoded; then, for each table searched, the range is
//   opened, P probes run and a closing range check follows; last, the
//   output register is loaded once it is free. P is the number of probes
//   (at most 9 for the boot table and 13 for the cartridge table).
// Throughput: one beat at a time; each probe is a RAM read and compare
//   through the single read port of the table being searched.
// Reset: synchronous, active low; clears both counts, the sequencer and the
//   output valid. Table RAMs are not cleared and must be loaded before use.
module code_symbol_lookup_unit
    import csl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration writes: index 0 boot_count, index 1 cart_count.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    // Input beats.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, low to high: entry_index[11:0], address[43:12],
    // name_handle[59:44], zero fill[63:60].
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: op[1:0].
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,

    // Result beats, one per lookup.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, low to high: symbol_handle[15:0], offset[47:16].
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // tuser, low to high: found[0], from_boot[1].
    output logic [M_TUSER_W-1:0]  m_axis_tuser
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // Count registers take a write in any cycle; software must only write them
    // while no beat is in flight, which the block itself does not enforce.
    assign o_cfg_ready = 1'b1;

    // The sequencer owns the input handshake. The output register lives in
    // the datapath, so a new beat is taken while a result still waits on the
    // master side.
    csl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The search keeps the last probed entry at or below the counter, so the
    // matching entry never needs a second read once the range closes.
    csl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

/* sv/csl_ram.sv */
// ============================================================================
// csl_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
module csl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* sv/csl_ctrl.sv */
// ============================================================================
// csl_ctrl
// Sequencer for the lookup block: decodes each beat, walks the binary search
// over one or both tables and hands the answer to the output register.
// ============================================================================
module csl_ctrl
    import csl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.op == OP_LOOKUP) begin
                    n_state = i_status.below_limit ? S_BOOT_INIT : S_CART_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BOOT_INIT: n_state = S_ISSUE;
            S_CART_INIT: n_state = S_ISSUE;
            S_ISSUE: begin
                if (!i_status.range_empty) begin
                    n_state = S_CHECK;
                end else if (!i_status.hit && i_status.table_boot) begin
                    // Nothing at or below the counter in boot ROM: fall back.
                    n_state = S_CART_INIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CHECK: n_state = S_ISSUE;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = (r_state == S_IDLE);
        o_cmd             = '0;
        o_cmd.capture     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.wr_boot     = (r_state == S_DECODE) && (i_status.op == OP_WR_BOOT);
        o_cmd.wr_cart     = (r_state == S_DECODE) && (i_status.op == OP_WR_CART);
        o_cmd.init        = (r_state == S_BOOT_INIT) || (r_state == S_CART_INIT);
        o_cmd.init_boot   = (r_state == S_BOOT_INIT);
        o_cmd.issue       = (r_state == S_ISSUE) && !i_status.range_empty;
        o_cmd.check       = (r_state == S_CHECK);
        o_cmd.publish     = (r_state == S_DONE) && i_status.out_free;
    end

    // A result is only moved into the output register when that register
    // can take it.
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> i_status.out_free)
        else $error("publish while output register is occupied");

endmodule

/* sv/csl_dp.sv */
// ============================================================================
// csl_dp
// Datapath for the lookup block: input holding registers, count registers,
// the two symbol tables, the search range registers and the output register.
// ============================================================================
module csl_dp
    import csl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    input  logic [S_TDATA_W-1:0]  i_in_data,
    input  logic [S_TUSER_W-1:0]  i_in_user,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [M_TDATA_W-1:0]  o_out_data,
    output logic [M_TUSER_W-1:0]  o_out_user
);

    // Held input beat.
    logic [OP_W-1:0]    r_op;
    logic [INDEX_W-1:0] r_index;
    logic [ADDR_W-1:0]  r_pc;
    logic [NAME_W-1:0]  r_name;

    logic [BOOT_CNT_W-1:0] r_boot_count;
    logic [CART_CNT_W-1:0] r_cart_count;

    // Search state.
    logic [PTR_W-1:0]  r_lo;
    logic [PTR_W-1:0]  r_hi;
    logic [PTR_W-1:0]  r_mid;
    logic              r_hit;
    logic              r_table_boot;
    logic [ADDR_W-1:0] r_hit_addr;
    logic [NAME_W-1:0] r_hit_name;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TUSER_W-1:0] r_out_user;

    logic [PTR_W:0]     w_sum;
    logic [PTR_W-1:0]   w_mid;
    logic [PTR_W-1:0]   w_boot_lim;
    logic [PTR_W-1:0]   w_cart_lim;
    logic [ENTRY_W-1:0] w_boot_rd;
    logic [ENTRY_W-1:0] w_cart_rd;
    logic [ENTRY_W-1:0] w_rd;
    logic               w_le;
    logic               w_out_free;

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[PTR_W:1];

    // Counts beyond the table depth act as the full table.
    assign w_boot_lim = (32'(r_boot_count) > BOOT_DEPTH) ? PTR_W'(BOOT_DEPTH)
                                                         : PTR_W'(r_boot_count);
    assign w_cart_lim = (32'(r_cart_count) > CART_DEPTH) ? PTR_W'(CART_DEPTH)
                                                         : PTR_W'(r_cart_count);

    assign w_rd       = r_table_boot ? w_boot_rd : w_cart_rd;
    assign w_le       = (w_rd[ADDR_W-1:0] <= r_pc);
    assign w_out_free = !r_out_valid || i_out_ready;

    csl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BOOT_DEPTH)
    ) u_boot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_boot && (32'(r_index) < BOOT_DEPTH)),
        .i_wr_addr (BOOT_AW'(r_index)),
        .i_wr_data ({r_name, r_pc}),
        .i_rd_en   (i_cmd.issue && r_table_boot),
        .i_rd_addr (BOOT_AW'(w_mid)),
        .o_rd_data (w_boot_rd)
    );

    csl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CART_DEPTH)
    ) u_cart_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_cart && (32'(r_index) < CART_DEPTH)),
        .i_wr_addr (CART_AW'(r_index)),
        .i_wr_data ({r_name, r_pc}),
        .i_rd_en   (i_cmd.issue && !r_table_boot),
        .i_rd_addr (CART_AW'(w_mid)),
        .o_rd_data (w_cart_rd)
    );

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_in_user;
            r_index <= i_in_data[INDEX_W-1:0];
            r_pc    <= i_in_data[INDEX_W +: ADDR_W];
            r_name  <= i_in_data[INDEX_W + ADDR_W +: NAME_W];
        end
        if (i_cmd.issue) begin
            r_mid <= w_mid;
        end
        if (i_cmd.check && w_le) begin
            r_hit_addr <= w_rd[ADDR_W-1:0];
            r_hit_name <= w_rd[ADDR_W +: NAME_W];
        end
        if (i_cmd.publish) begin
            r_out_user <= {r_hit & r_table_boot, r_hit};
            r_out_data <= r_hit ? {r_pc - r_hit_addr, r_hit_name} : '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_count <= '0;
            r_cart_count <= '0;
            r_lo         <= '0;
            r_hi         <= '0;
            r_hit        <= 1'b0;
            r_table_boot <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_BOOT_COUNT: r_boot_count <= i_cfg_data[BOOT_CNT_W-1:0];
                    CFG_CART_COUNT: r_cart_count <= i_cfg_data[CART_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.init) begin
                r_lo         <= '0;
                r_hi         <= i_cmd.init_boot ? w_boot_lim : w_cart_lim;
                r_hit        <= 1'b0;
                r_table_boot <= i_cmd.init_boot;
            end else if (i_cmd.check) begin
                if (w_le) begin
                    r_lo  <= PTR_W'(r_mid + 1'b1);
                    r_hit <= 1'b1;
                end else begin
                    r_hi <= r_mid;
                end
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status             = '0;
        o_status.op          = t_op'(r_op);
        o_status.below_limit = ({1'b0, r_pc} < BOOT_LIMIT);
        o_status.range_empty = (r_lo == r_hi);
        o_status.hit         = r_hit;
        o_status.table_boot  = r_table_boot;
        o_status.out_free    = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

    // The search range never inverts.
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("search range inverted");

    // A compare always consumes the read issued in the cycle before.
    a_check_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.check |-> $past(i_cmd.issue))
        else $error("compare without a preceding table read");

    // A miss carries an all-zero payload and no table flag.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_user[0]) |-> (r_out_data == '0 && !r_out_user[1]))
        else $error("miss result carries nonzero payload");

endmodule
